/* src/angle_bias_kalman_filter_macros.svh */
// Assertion macros for the angle and bias Kalman filter.
// Used by the top level; relies on ports named clock and reset.
`ifndef ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`define ANGLE_BIAS_KALMAN_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define ABKF_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define ABKF_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ABKF_ASSERT(lbl, prop)
`define ABKF_NEVER(lbl, cond)
`endif
`endif

/* src/abkf_pkg.sv */
// Shared types, constants and saturation helpers for the Kalman filter.
// No dependencies.
`timescale 1ns / 1ps
package abkf_pkg;
   localparam int NUM_CHANNELS = 2;
   localparam int DIV_STEPS = 56;
   localparam int DIV_CNT_W = 6;
   localparam logic [30:0] APN_RESET = 31'd83886;
   localparam logic [30:0] BPN_RESET = 31'd50332;
   localparam logic [30:0] MN_RESET = 31'd15938355;
   localparam logic [23:0] DT_RESET = 24'd33554;
   localparam logic signed [31:0] Q24_ONE = 32'sd16777216;
   localparam logic [1:0] CSR_APN = 2'd0;
   localparam logic [1:0] CSR_BPN = 2'd1;
   localparam logic [1:0] CSR_MN = 2'd2;
   localparam logic [1:0] CSR_DT = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
      logic signed [31:0] r;
      if (x > 48'sh0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (x < -48'sh0000_8000_0000) r = -32'sh8000_0000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [43:0] p);
      logic signed [47:0] s;
      s = $signed({{16{a[31]}}, a}) + $signed({{4{p[43]}}, p});
      return sat32(s);
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [43:0] p);
      logic signed [47:0] s;
      s = $signed({{16{a[31]}}, a}) - $signed({{4{p[43]}}, p});
      return sat32(s);
   endfunction
endpackage

/* src/abkf_mul.sv */
// Shared signed multiplier with registered, floor-shifted (>>24) product.
// Depends on nothing but the timescale.
`timescale 1ns / 1ps
module abkf_mul (
   input  logic               clock,
   input  logic signed [34:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [43:0] prod_ff
);
   logic signed [67:0] full;
   logic signed [43:0] prod_in;

   assign full = op_a * op_b;
   assign prod_in = full[67:24];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

/* src/abkf_div.sv */
// Bit-serial restoring divider: sat32((num * 2^24) / den), truncating toward zero.
// Depends on abkf_pkg.
`timescale 1ns / 1ps
module abkf_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [31:0]        num,
   input  logic [31:0]               den,
   output abkf_pkg::div_status_type  status,
   output logic signed [31:0]        quot
);
   logic [abkf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [55:0] q_ff, q_in;
   logic [31:0] rem_ff, rem_in, den_ff, den_in;
   logic neg_ff, neg_in;
   logic [32:0] trial;
   logic [31:0] mag;

   assign trial = {rem_ff, q_ff[55]};
   assign mag = num[31] ? 32'(-num) : num;

   always_comb begin
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      q_in = q_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (start) begin
         cnt_in = (abkf_pkg::DIV_CNT_W)'(abkf_pkg::DIV_STEPS);
         busy_in = 1'b1;
         q_in = {mag, 24'd0};
         rem_in = '0;
         den_in = den;
         neg_in = num[31];
      end else if (busy_ff) begin
         // restore when the trial remainder falls below the divisor
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 32'(trial - {1'b0, den_ff});
            q_in = {q_ff[54:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            q_in = {q_ff[54:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == (abkf_pkg::DIV_CNT_W)'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (q_ff > 56'h80000000) quot = -32'sh8000_0000;
         else quot = 32'(-q_ff[31:0]);
      end else begin
         if (q_ff > 56'h7FFFFFFF) quot = 32'sh7FFF_FFFF;
         else quot = q_ff[31:0];
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end
endmodule

/* src/angle_bias_kalman_filter.sv */
// Two-state (angle, gyro bias) Kalman filter per channel, one shared multiplier.
// Per item: four predict multiplies, each issued and then applied, two divisions for the
// gains (start, 56 serial steps, done), six correct multiplies and a hand-off to the
// output register, which waits while the output stalls. One item at a time; the next is
// taken only after the filter returns to idle. Synchronous active-high reset restores the
// noise registers and the filter state (angle and bias zero, covariance identity).
`timescale 1ns / 1ps
`include "angle_bias_kalman_filter_macros.svh"
module angle_bias_kalman_filter (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_channel,
   input  logic signed [31:0] req_gyro_rate,
   input  logic signed [31:0] req_accel_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_angle_estimate,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ISSUE = 3'd1;
   localparam logic [2:0] S_APPLY = 3'd2;
   localparam logic [2:0] S_DSTART = 3'd3;
   localparam logic [2:0] S_DWAIT = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;
   localparam logic [3:0] OP_LAST_PREDICT = 4'd3;
   localparam logic [3:0] OP_FIRST_CORRECT = 4'd4;
   localparam logic [3:0] OP_LAST = 4'd9;

   logic [30:0] apn_ff, bpn_ff, mn_ff;
   logic [23:0] dt_ff;
   logic signed [31:0] ang_st_ff [abkf_pkg::NUM_CHANNELS];
   logic signed [31:0] bias_st_ff [abkf_pkg::NUM_CHANNELS];
   logic signed [31:0] p00_st_ff [abkf_pkg::NUM_CHANNELS];
   logic signed [31:0] p01_st_ff [abkf_pkg::NUM_CHANNELS];
   logic signed [31:0] p10_st_ff [abkf_pkg::NUM_CHANNELS];
   logic signed [31:0] p11_st_ff [abkf_pkg::NUM_CHANNELS];

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic dsel_ff, dsel_in;
   logic ch_ff, ch_in;
   logic signed [31:0] rate_ff, rate_in, meas_ff, meas_in;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, err_ff, err_in;
   logic signed [31:0] t0_ff, t0_in, t1_ff, t1_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_ff, rsp_in;

   logic signed [34:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [43:0] prod;
   logic div_start;
   logic signed [31:0] div_num, quot;
   logic [31:0] div_den;
   abkf_pkg::div_status_type div_st;
   logic signed [32:0] e_sum;

   abkf_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));

   abkf_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .status(div_st), .quot(quot)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle_estimate = rsp_ff;

   // innovation variance, clamped to one LSB when not positive
   assign e_sum = $signed({2'b00, mn_ff}) + $signed({p00_ff[31], p00_ff});
   assign div_den = (e_sum <= 33'sd0) ? 32'd1 : e_sum[31:0];
   assign div_num = dsel_ff ? p10_ff : p00_ff;
   assign div_start = (state_ff == S_DSTART);

   always_comb begin
      mul_a = '0;
      mul_b = $signed({9'd0, dt_ff});
      case (op_ff)
         4'd0: mul_a = $signed({{3{rate_ff[31]}}, rate_ff})
                     - $signed({{3{bias_ff[31]}}, bias_ff});
         4'd1: mul_a = $signed({4'd0, apn_ff}) - $signed({{3{p01_ff[31]}}, p01_ff})
                     - $signed({{3{p10_ff[31]}}, p10_ff});
         4'd2: mul_a = $signed({{3{p11_ff[31]}}, p11_ff});
         4'd3: mul_a = $signed({4'd0, bpn_ff});
         4'd4, 4'd5: begin
            mul_a = (op_ff == 4'd4) ? $signed({{3{k0_ff[31]}}, k0_ff})
                                    : $signed({{3{k1_ff[31]}}, k1_ff});
            mul_b = $signed({err_ff[31], err_ff});
         end
         4'd6, 4'd7, 4'd8, 4'd9: begin
            mul_a = (op_ff < 4'd8) ? $signed({{3{k0_ff[31]}}, k0_ff})
                                   : $signed({{3{k1_ff[31]}}, k1_ff});
            mul_b = op_ff[0] ? $signed({t1_ff[31], t1_ff}) : $signed({t0_ff[31], t0_ff});
         end
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      dsel_in = dsel_ff;
      ch_in = ch_ff;
      rate_in = rate_ff;
      meas_in = meas_ff;
      ang_in = ang_ff;
      bias_in = bias_ff;
      p00_in = p00_ff;
      p01_in = p01_ff;
      p10_in = p10_ff;
      p11_in = p11_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      err_in = err_ff;
      t0_in = t0_ff;
      t1_in = t1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in = req_channel;
               rate_in = req_gyro_rate;
               meas_in = req_accel_angle;
               ang_in = ang_st_ff[req_channel];
               bias_in = bias_st_ff[req_channel];
               p00_in = p00_st_ff[req_channel];
               p01_in = p01_st_ff[req_channel];
               p10_in = p10_st_ff[req_channel];
               p11_in = p11_st_ff[req_channel];
               op_in = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: state_in = S_APPLY;
         S_APPLY: begin
            case (op_ff)
               4'd0: ang_in = abkf_pkg::add_sat(ang_ff, prod);
               4'd1: p00_in = abkf_pkg::add_sat(p00_ff, prod);
               4'd2: begin
                  p01_in = abkf_pkg::sub_sat(p01_ff, prod);
                  p10_in = abkf_pkg::sub_sat(p10_ff, prod);
               end
               4'd3: p11_in = abkf_pkg::add_sat(p11_ff, prod);
               4'd4: ang_in = abkf_pkg::add_sat(ang_ff, prod);
               4'd5: bias_in = abkf_pkg::add_sat(bias_ff, prod);
               4'd6: p00_in = abkf_pkg::sub_sat(p00_ff, prod);
               4'd7: p01_in = abkf_pkg::sub_sat(p01_ff, prod);
               4'd8: p10_in = abkf_pkg::sub_sat(p10_ff, prod);
               4'd9: p11_in = abkf_pkg::sub_sat(p11_ff, prod);
               default: ang_in = ang_ff;
            endcase
            if (op_ff == OP_LAST_PREDICT) begin
               dsel_in = 1'b0;
               state_in = S_DSTART;
            end else if (op_ff == OP_LAST) begin
               state_in = S_DONE;
            end else begin
               op_in = op_ff + 1'b1;
               state_in = S_ISSUE;
            end
         end
         S_DSTART: begin
            // snapshot the predicted covariance and the innovation
            t0_in = p00_ff;
            t1_in = p01_ff;
            err_in = abkf_pkg::sat32($signed({{16{meas_ff[31]}}, meas_ff})
                                     - $signed({{16{ang_ff[31]}}, ang_ff}));
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_st.done) begin
               if (!dsel_ff) begin
                  k0_in = quot;
                  dsel_in = 1'b1;
                  state_in = S_DSTART;
               end else begin
                  k1_in = quot;
                  op_in = OP_FIRST_CORRECT;
                  state_in = S_ISSUE;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = ang_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff <= '0;
         dsel_ff <= 1'b0;
         apn_ff <= abkf_pkg::APN_RESET;
         bpn_ff <= abkf_pkg::BPN_RESET;
         mn_ff <= abkf_pkg::MN_RESET;
         dt_ff <= abkf_pkg::DT_RESET;
         for (int i = 0; i < abkf_pkg::NUM_CHANNELS; i++) begin
            ang_st_ff[i] <= '0;
            bias_st_ff[i] <= '0;
            p00_st_ff[i] <= abkf_pkg::Q24_ONE;
            p01_st_ff[i] <= '0;
            p10_st_ff[i] <= '0;
            p11_st_ff[i] <= abkf_pkg::Q24_ONE;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff <= op_in;
         dsel_ff <= dsel_in;
         if (csr_write) begin
            case (csr_index)
               abkf_pkg::CSR_APN: apn_ff <= csr_data;
               abkf_pkg::CSR_BPN: bpn_ff <= csr_data;
               abkf_pkg::CSR_MN: mn_ff <= csr_data;
               abkf_pkg::CSR_DT: dt_ff <= csr_data[23:0];
               default: dt_ff <= dt_ff;
            endcase
         end
         if (state_ff == S_DONE) begin
            ang_st_ff[ch_ff] <= ang_ff;
            bias_st_ff[ch_ff] <= bias_ff;
            p00_st_ff[ch_ff] <= p00_ff;
            p01_st_ff[ch_ff] <= p01_ff;
            p10_st_ff[ch_ff] <= p10_ff;
            p11_st_ff[ch_ff] <= p11_ff;
         end
      end
      ch_ff <= ch_in;
      rate_ff <= rate_in;
      meas_ff <= meas_in;
      ang_ff <= ang_in;
      bias_ff <= bias_in;
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      p11_ff <= p11_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      err_ff <= err_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      rsp_ff <= rsp_in;
   end

   `ABKF_ASSERT(a_accept_busy, (req_valid && req_ready) |=> !req_ready)
   `ABKF_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
   `ABKF_NEVER(a_start_while_busy, div_start && div_st.busy)
   `ABKF_NEVER(a_done_outside_wait, div_st.done && state_ff != S_DWAIT)
endmodule
